FILE: hdl/tofr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofr_pkg - shared constants for the ultrasonic time-of-flight range unit
// Field widths, sound-speed and distance constants, reciprocal multipliers
// and configuration register indexes.
// ----------------------------------------------------------------------------
package tofr_pkg;

    // default parameter values
    localparam int SENSOR_ID_BITS_DEF = 4;
    localparam int TOF_BITS_DEF       = 15;

    // configuration field widths
    localparam int TEMP_W    = 11;
    localparam int SPACING_W = 8;

    // result field widths
    localparam int DIST_W  = 14;
    localparam int RANGE_W = 13;

    // configuration register indexes (paddr bit 2)
    localparam logic REG_TEMPERATURE = 1'b0;
    localparam logic REG_SPACING     = 1'b1;

    // reset values of the configuration registers
    localparam logic signed [TEMP_W-1:0] TEMP_RESET    = 11'sd210;
    localparam logic [SPACING_W-1:0]     SPACING_RESET = 8'd12;

    // speed numerator: 3313000 + 606 * T, always positive, fits 22 bits
    localparam int NUM_W     = 24;
    localparam int SPD_NUM_W = 22;
    localparam logic signed [NUM_W-1:0] SOUND_BASE  = 24'sd3313000;
    localparam logic signed [NUM_W-1:0] SOUND_SLOPE = 24'sd606;

    // floor(n / 10000) = (n * ceil(2^37 / 10000)) >> 37 for n < 2^22
    localparam int SPD_RECIP_W = 24;
    localparam logic [SPD_RECIP_W-1:0] SPD_RECIP = 24'd13743896;
    localparam int SPD_SHIFT = 37;
    localparam int SPEED_W   = 9;

    // floor(p / 2000) = (p * ceil(2^36 / 2000)) >> 36 for p < 2^25
    localparam int DIST_RECIP_W = 26;
    localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 26'd34359739;
    localparam int DIST_SHIFT = 36;

    // quotient minus offset, saturated
    localparam int DQ_W = 17;
    localparam logic signed [DQ_W-1:0] DIST_OFFSET = 17'sd20;
    localparam logic signed [DQ_W-1:0] DIST_SAT    = 17'sd8191;

    localparam logic [RANGE_W-1:0] RANGE_MAX = 13'h1FFF;

endpackage

FILE: hdl/ultrasonic_tof_to_range_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_tof_to_range_unit - echo time of flight to path distance and range
// Speed of sound from temperature, half path length, half baseline between
// sensors and a pipelined floor square root for the perpendicular range.
//
//  channel  direction  tdata (low bit first)                     tuser
//  s_       in         transmitter_id, receiver_id,              -
//                      time_of_flight
//  m_       out        path_distance, obstacle_range             geometry_error
//  apb      in/out     0x0 temperature_tenths, 0x4 sensor_spacing_mm
//
// One item per cycle sustained while m_tready is high. Items pass the
// distance, geometry and square root stages and the output register;
// the square root stages, up to two root bits each, grow with the root width.
// Reset is synchronous, active low; it clears valid bits and restores the
// configuration registers. A two-entry output buffer takes one more item
// while m_tready is low; after that the whole pipeline holds.
// ----------------------------------------------------------------------------
module ultrasonic_tof_to_range_unit
    import tofr_pkg::*;
#(
    parameter int SENSOR_ID_BITS = SENSOR_ID_BITS_DEF,
    parameter int TOF_BITS       = TOF_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // transmitter_id, receiver_id, time_of_flight
    input  logic [((2*SENSOR_ID_BITS+TOF_BITS+7)/8)*8-1:0] s_tdata,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,  // path_distance, obstacle_range
    output logic [0:0]            m_tuser,  // geometry_error
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int H_W    = SPACING_W + SENSOR_ID_BITS - 1;
    localparam int DH_W   = ((H_W + 1 > DIST_W) ? H_W + 1 : DIST_W) + 1;
    localparam int RAD_W  = 2 * DH_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int PAD_W  = 32 - DIST_W - RANGE_W;

    // configuration registers
    logic signed [TEMP_W-1:0] temperature_tenths_reg;
    logic [SPACING_W-1:0]     sensor_spacing_mm_reg;

    logic cfg_write;

    // pipeline links
    logic                      adv;
    logic                      d_valid, g_valid, q_valid;
    logic [SENSOR_ID_BITS-1:0] d_tx, d_rx;
    logic signed [DIST_W-1:0]  d_dist, g_dist, q_dist;
    logic                      g_same, q_same, q_neg;
    logic signed [RAD_W-1:0]   g_rad;
    logic [ROOT_W-1:0]         q_root;

    // result and output buffer
    logic [RANGE_W-1:0]       range_next;
    logic                     err_next;
    logic                     out_valid_reg, skid_valid_reg;
    logic signed [DIST_W-1:0] out_dist_reg, skid_dist_reg;
    logic [RANGE_W-1:0]       out_range_reg, skid_range_reg;
    logic                     out_err_reg, skid_err_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temperature_tenths_reg <= TEMP_RESET;
            sensor_spacing_mm_reg  <= SPACING_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_TEMPERATURE: temperature_tenths_reg <= $signed(pwdata[TEMP_W-1:0]);
                REG_SPACING:     sensor_spacing_mm_reg  <= pwdata[SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEMPERATURE: prdata = 32'(unsigned'(temperature_tenths_reg));
            REG_SPACING:     prdata = 32'(sensor_spacing_mm_reg);
            default:         prdata = '0;
        endcase
    end

    // the pipeline moves whenever the skid entry is free
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    tofr_dist #(
        .SENSOR_ID_BITS (SENSOR_ID_BITS),
        .TOF_BITS       (TOF_BITS)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (s_tvalid),
        .in_tx       (s_tdata[SENSOR_ID_BITS-1:0]),
        .in_rx       (s_tdata[2*SENSOR_ID_BITS-1:SENSOR_ID_BITS]),
        .in_tof      (s_tdata[2*SENSOR_ID_BITS +: TOF_BITS]),
        .temperature (temperature_tenths_reg),
        .out_valid   (d_valid),
        .out_tx      (d_tx),
        .out_rx      (d_rx),
        .out_dist    (d_dist)
    );

    tofr_geom #(
        .SENSOR_ID_BITS (SENSOR_ID_BITS),
        .RAD_W          (RAD_W)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d_valid),
        .in_tx     (d_tx),
        .in_rx     (d_rx),
        .in_dist   (d_dist),
        .spacing   (sensor_spacing_mm_reg),
        .out_valid (g_valid),
        .out_same  (g_same),
        .out_dist  (g_dist),
        .out_rad   (g_rad)
    );

    tofr_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (g_valid),
        .in_same   (g_same),
        .in_dist   (g_dist),
        .in_rad    (g_rad),
        .out_valid (q_valid),
        .out_same  (q_same),
        .out_neg   (q_neg),
        .out_dist  (q_dist),
        .out_root  (q_root)
    );

    // pick the range: distance itself for one sensor, else the clipped root
    always_comb begin
        if (q_same) begin
            err_next   = q_dist[DIST_W-1];
            range_next = err_next ? '0 : q_dist[RANGE_W-1:0];
        end else begin
            err_next = q_neg;
            if (q_neg) begin
                range_next = '0;
            end else if (q_root > ROOT_W'(RANGE_MAX)) begin
                range_next = RANGE_MAX;
            end else begin
                range_next = q_root[RANGE_W-1:0];
            end
        end
    end

    // output register and skid entry: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (q_valid) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register and skid entry: payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_dist_reg  <= skid_dist_reg;
                out_range_reg <= skid_range_reg;
                out_err_reg   <= skid_err_reg;
            end
        end else if (q_valid) begin
            if (!out_valid_reg || m_tready) begin
                out_dist_reg  <= q_dist;
                out_range_reg <= range_next;
                out_err_reg   <= err_next;
            end else begin
                skid_dist_reg  <= q_dist;
                skid_range_reg <= range_next;
                skid_err_reg   <= err_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_range_reg, out_dist_reg};
    assign m_tuser  = out_err_reg;

    // the skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output is empty");

    // a stalled output with a new item arriving fills the skid entry
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (!skid_valid_reg && q_valid && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("item from the pipeline was not caught by the skid entry");

    // a geometry error always comes with a zero range
    a_err_zero_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_err_reg) |-> (out_range_reg == '0))
        else $error("geometry error with a nonzero range");

endmodule

FILE: hdl/tofr_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofr_dist - speed of sound and path distance pipeline
// Five stages: speed numerator, speed quotient, time-of-flight product,
// quotient by 2000, offset and saturation. Sensor IDs travel alongside.
// ----------------------------------------------------------------------------
module tofr_dist
    import tofr_pkg::*;
#(
    parameter int SENSOR_ID_BITS = SENSOR_ID_BITS_DEF,
    parameter int TOF_BITS       = TOF_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [SENSOR_ID_BITS-1:0] in_tx,
    input  logic [SENSOR_ID_BITS-1:0] in_rx,
    input  logic [TOF_BITS-1:0]       in_tof,
    input  logic signed [TEMP_W-1:0]  temperature,
    output logic                      out_valid,
    output logic [SENSOR_ID_BITS-1:0] out_tx,
    output logic [SENSOR_ID_BITS-1:0] out_rx,
    output logic signed [DIST_W-1:0]  out_dist
);

    localparam int NSTAGE  = 5;
    localparam int SPD_P_W = SPD_NUM_W + SPD_RECIP_W;
    localparam int PROD_W  = TOF_BITS + SPEED_W;
    localparam int DP_W    = PROD_W + DIST_RECIP_W;
    localparam int Q_W     = TOF_BITS - 1;

    logic [NSTAGE-1:0]         vld_reg;
    logic [SENSOR_ID_BITS-1:0] tx_reg [NSTAGE];
    logic [SENSOR_ID_BITS-1:0] rx_reg [NSTAGE];

    logic [TOF_BITS-1:0]  tof1_reg, tof2_reg;
    logic [SPD_NUM_W-1:0] num1_reg;
    logic [SPEED_W-1:0]   speed2_reg;
    logic [PROD_W-1:0]    prod3_reg;
    logic [Q_W-1:0]       q4_reg;
    logic signed [DIST_W-1:0] dist5_reg;

    logic signed [NUM_W-1:0]  temp_ext;
    logic signed [NUM_W-1:0]  num_next;
    logic [SPD_P_W-1:0]       spd_prod;
    logic [SPEED_W-1:0]       speed_next;
    logic [PROD_W-1:0]        prod_next;
    logic [DP_W-1:0]          dist_prod;
    logic [Q_W-1:0]           q_next;
    logic signed [DQ_W-1:0]   dd;
    logic signed [DIST_W-1:0] dist_next;

    // stage 1: speed numerator from the current temperature
    assign temp_ext = NUM_W'(temperature);
    assign num_next = SOUND_BASE + SOUND_SLOPE * temp_ext;

    // stage 2: divide by 10000 through the reciprocal
    assign spd_prod   = SPD_P_W'(num1_reg) * SPD_P_W'(SPD_RECIP);
    assign speed_next = spd_prod[SPD_SHIFT +: SPEED_W];

    // stage 3: time of flight times speed
    assign prod_next = PROD_W'(tof2_reg) * PROD_W'(speed2_reg);

    // stage 4: divide by 2000 through the reciprocal
    assign dist_prod = DP_W'(prod3_reg) * DP_W'(DIST_RECIP);
    assign q_next    = dist_prod[DIST_SHIFT +: Q_W];

    // stage 5: subtract the offset, clip the top
    assign dd        = $signed(DQ_W'(q4_reg)) - DIST_OFFSET;
    assign dist_next = (dd > DIST_SAT) ? DIST_W'(DIST_SAT) : dd[DIST_W-1:0];

    // advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    // advance the payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg[0]  <= in_tx;
            rx_reg[0]  <= in_rx;
            for (int i = 1; i < NSTAGE; i++) begin
                tx_reg[i] <= tx_reg[i-1];
                rx_reg[i] <= rx_reg[i-1];
            end
            tof1_reg   <= in_tof;
            num1_reg   <= num_next[SPD_NUM_W-1:0];
            tof2_reg   <= tof1_reg;
            speed2_reg <= speed_next;
            prod3_reg  <= prod_next;
            q4_reg     <= q_next;
            dist5_reg  <= dist_next;
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign out_tx    = tx_reg[NSTAGE-1];
    assign out_rx    = rx_reg[NSTAGE-1];
    assign out_dist  = dist5_reg;

endmodule

FILE: hdl/tofr_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofr_geom - half baseline and radicand pipeline
// Three stages: half baseline from the sensor separation, sum and difference
// with the path distance, and their signed product.
// ----------------------------------------------------------------------------
module tofr_geom
    import tofr_pkg::*;
#(
    parameter int SENSOR_ID_BITS = SENSOR_ID_BITS_DEF,
    parameter int RAD_W          = 30
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [SENSOR_ID_BITS-1:0]  in_tx,
    input  logic [SENSOR_ID_BITS-1:0]  in_rx,
    input  logic signed [DIST_W-1:0]   in_dist,
    input  logic [SPACING_W-1:0]       spacing,
    output logic                       out_valid,
    output logic                       out_same,
    output logic signed [DIST_W-1:0]   out_dist,
    output logic signed [RAD_W-1:0]    out_rad
);

    localparam int NSTAGE = 3;
    localparam int HP_W   = SPACING_W + SENSOR_ID_BITS;
    localparam int H_W    = HP_W - 1;
    localparam int DH_W   = RAD_W / 2;

    logic [NSTAGE-1:0]        vld_reg;
    logic                     same_reg [NSTAGE];
    logic signed [DIST_W-1:0] dist_reg [NSTAGE];

    logic [H_W-1:0]          h1_reg;
    logic signed [DH_W-1:0]  sum2_reg, diff2_reg;
    logic signed [RAD_W-1:0] rad3_reg;

    logic [SENSOR_ID_BITS-1:0] sep_next;
    logic [HP_W-1:0]           h_prod;
    logic signed [DH_W-1:0]    d_ext, h_ext;
    logic signed [DH_W-1:0]    sum_next, diff_next;
    logic signed [RAD_W-1:0]   rad_next;

    // stage 1: half baseline = spacing * |tx - rx| / 2
    assign sep_next = (in_tx > in_rx) ? (in_tx - in_rx) : (in_rx - in_tx);
    assign h_prod   = HP_W'(spacing) * HP_W'(sep_next);

    // stage 2: d + h and d - h
    assign d_ext     = DH_W'(dist_reg[0]);
    assign h_ext     = $signed(DH_W'(h1_reg));
    assign sum_next  = d_ext + h_ext;
    assign diff_next = d_ext - h_ext;

    // stage 3: radicand
    assign rad_next = RAD_W'(sum2_reg) * RAD_W'(diff2_reg);

    // advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    // advance the payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            same_reg[0] <= (in_tx == in_rx);
            dist_reg[0] <= in_dist;
            for (int i = 1; i < NSTAGE; i++) begin
                same_reg[i] <= same_reg[i-1];
                dist_reg[i] <= dist_reg[i-1];
            end
            h1_reg    <= h_prod[HP_W-1:1];
            sum2_reg  <= sum_next;
            diff2_reg <= diff_next;
            rad3_reg  <= rad_next;
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign out_same  = same_reg[NSTAGE-1];
    assign out_dist  = dist_reg[NSTAGE-1];
    assign out_rad   = rad3_reg;

endmodule

FILE: hdl/tofr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofr_sqrt - pipelined floor square root
// Digit-by-digit root, two result bits per stage, one in the last stage when
// the root width is odd. A negative radicand is flagged at entry and rooted
// as zero. Distance and same-sensor flag travel alongside.
// ----------------------------------------------------------------------------
module tofr_sqrt
    import tofr_pkg::*;
#(
    parameter int RAD_W = 30
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic                      in_same,
    input  logic signed [DIST_W-1:0]  in_dist,
    input  logic signed [RAD_W-1:0]   in_rad,
    output logic                      out_valid,
    output logic                      out_same,
    output logic                      out_neg,
    output logic signed [DIST_W-1:0]  out_dist,
    output logic [RAD_W/2-1:0]        out_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int NST    = (ROOT_W + 1) / 2;

    logic [NST-1:0]           vld_reg;
    logic                     same_reg [NST];
    logic                     neg_reg  [NST];
    logic signed [DIST_W-1:0] dist_reg [NST];
    logic [RAD_W-1:0]         v_reg    [NST];
    logic [REM_W-1:0]         rem_reg  [NST];
    logic [ROOT_W-1:0]        root_reg [NST];

    logic             in_neg;
    logic [RAD_W-1:0] in_v;

    // a negative radicand roots as zero
    assign in_neg = in_rad[RAD_W-1];
    assign in_v   = in_neg ? '0 : RAD_W'(in_rad);

    // advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [RAD_W-1:0]  v_in, v_next;
        logic [REM_W-1:0]  rem_in, rem_next, trial;
        logic [ROOT_W-1:0] root_in, root_next;
        logic              same_in, neg_in;
        logic signed [DIST_W-1:0] dist_in;

        if (k == 0) begin : g_first
            assign v_in    = in_v;
            assign rem_in  = '0;
            assign root_in = '0;
            assign same_in = in_same;
            assign neg_in  = in_neg;
            assign dist_in = in_dist;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign same_in = same_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign dist_in = dist_reg[k-1];
        end

        // up to two root bits: bring down a digit pair, try 4*root+1
        always_comb begin
            v_next    = v_in;
            rem_next  = rem_in;
            root_next = root_in;
            trial     = '0;
            for (int j = 0; j < 2; j++) begin
                if (k * 2 + j < ROOT_W) begin
                    rem_next = {rem_next[REM_W-3:0], v_next[RAD_W-1 -: 2]};
                    v_next   = v_next << 2;
                    trial    = {1'b0, root_next, 2'b01};
                    if (rem_next >= trial) begin
                        rem_next  = rem_next - trial;
                        root_next = {root_next[ROOT_W-2:0], 1'b1};
                    end else begin
                        root_next = {root_next[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        // hold the stage while stalled
        always_ff @(posedge aclk) begin
            if (adv) begin
                v_reg[k]    <= v_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                same_reg[k] <= same_in;
                neg_reg[k]  <= neg_in;
                dist_reg[k] <= dist_in;
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_same  = same_reg[NST-1];
    assign out_neg   = neg_reg[NST-1];
    assign out_dist  = dist_reg[NST-1];
    assign out_root  = root_reg[NST-1];

endmodule
